// ===== src/pidtaw_pkg.sv =====
package pidtaw_pkg;

    // Field and state widths (Q16.16)
    localparam int GAIN_W   = 31;
    localparam int DATA_W   = 32;
    localparam int ERR_W    = 33;
    localparam int DIFF_W   = 34;
    localparam int INTEG_W  = 48;
    localparam int MUL_OP_W = 49;
    localparam int ACC_W    = 64;
    localparam int CFG_IDX_W = 3;

    // Integral saturation bounds
    localparam logic signed [INTEG_W-1:0] INT48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [INTEG_W-1:0] INT48_MIN = 48'sh8000_0000_0000;

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_UPPER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LOWER = 3'd4;

    // Beat codes on the mode field
    localparam logic MODE_STEP  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    // Register reset values
    localparam logic [GAIN_W-1:0]        GAIN_RESET  = '0;
    localparam logic signed [DATA_W-1:0] UPPER_RESET = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] LOWER_RESET = 32'sh8000_0000;

    // Restoring divider: one quotient bit per cycle
    localparam int DIV_STEPS = 48;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
    typedef logic [DIV_CNT_W-1:0] div_cnt_t;

    // Multiplier digit width (gain is split into two digits)
    localparam int DIGIT_W = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_INTEG,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic en;
        logic first;
    } mul_ctl_t;

    typedef struct packed {
        logic busy;
        logic last;
    } div_stat_t;

endpackage

// ===== src/pidtaw_div.sv =====
module pidtaw_div (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [pidtaw_pkg::INTEG_W-1:0]         dividend,
    input  logic [pidtaw_pkg::GAIN_W-1:0]          divisor,
    output logic [pidtaw_pkg::INTEG_W-1:0]         quotient,
    output pidtaw_pkg::div_stat_t                  stat
);

    pidtaw_pkg::div_cnt_t                   cnt_reg, cnt_next;
    logic [pidtaw_pkg::GAIN_W-1:0]          rem_reg, rem_next;
    logic [pidtaw_pkg::INTEG_W-1:0]         q_reg, q_next;
    logic [pidtaw_pkg::GAIN_W-1:0]          div_reg, div_next;
    logic [pidtaw_pkg::GAIN_W:0]            trial;
    logic [pidtaw_pkg::GAIN_W+1:0]          diff;

    // One shift-subtract step per cycle
    always_comb
    begin
        trial     = {rem_reg, q_reg[pidtaw_pkg::INTEG_W-1]};
        diff      = {1'b0, trial} - {2'b00, div_reg};
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        div_next  = div_reg;
        if (start)
        begin
            cnt_next = pidtaw_pkg::div_cnt_t'(pidtaw_pkg::DIV_STEPS);
            rem_next = '0;
            q_next   = dividend;
            div_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (!diff[pidtaw_pkg::GAIN_W+1])
            begin
                rem_next = diff[pidtaw_pkg::GAIN_W-1:0];
                q_next   = {q_reg[pidtaw_pkg::INTEG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[pidtaw_pkg::GAIN_W-1:0];
                q_next   = {q_reg[pidtaw_pkg::INTEG_W-2:0], 1'b0};
            end
        end
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Remainder, quotient and divisor
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        div_reg <= div_next;
    end

    assign quotient  = q_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.last = (cnt_reg == pidtaw_pkg::div_cnt_t'(1));

    // Partial remainder stays below the divisor while dividing
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");

endmodule

// ===== src/pidtaw_mul.sv =====
module pidtaw_mul (
    input  logic                                    clk,
    input  pidtaw_pkg::mul_ctl_t                    ctl,
    input  logic [pidtaw_pkg::GAIN_W-1:0]           gain,
    input  logic signed [pidtaw_pkg::MUL_OP_W-1:0]  operand,
    output logic signed [pidtaw_pkg::ACC_W-1:0]     acc
);

    localparam int PROD_W = pidtaw_pkg::MUL_OP_W + pidtaw_pkg::DIGIT_W + 1;

    logic [pidtaw_pkg::DIGIT_W-1:0]          digit;
    logic signed [PROD_W-1:0]                prod;
    logic signed [pidtaw_pkg::ACC_W-1:0]     acc_reg, acc_next;

    // Low digit first, scaled down by 2^16 (floor); high digit then adds in place
    always_comb
    begin
        digit = ctl.first ? gain[pidtaw_pkg::DIGIT_W-1:0]
                          : {1'b0, gain[pidtaw_pkg::GAIN_W-1:pidtaw_pkg::DIGIT_W]};
        prod  = operand * $signed({1'b0, digit});
        if (ctl.first)
        begin
            acc_next = pidtaw_pkg::ACC_W'(prod >>> pidtaw_pkg::DIGIT_W);
        end
        else
        begin
            acc_next = acc_reg + $signed(prod[pidtaw_pkg::ACC_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== src/pid_trapezoid_antiwindup.sv =====
// A compute beat runs a restoring divide for the integral limit when gain_i is nonzero,
// then the integral update and three two-digit multiplies (P, I, D) on one shared 49x17
// multiplier; with gain_i zero the divide is skipped. A new beat is taken only in idle,
// after the last drive beat has been loaded; a clear beat leaves the sequencer idle.
// Reset (rst_n, async low): registers to defaults, integral and last error to zero.
module pid_trapezoid_antiwindup (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  mode,
    input  logic signed [pidtaw_pkg::DATA_W-1:0]  target,
    input  logic signed [pidtaw_pkg::DATA_W-1:0]  measured,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [pidtaw_pkg::DATA_W-1:0]  drive,
    input  logic                                  cfg_we,
    input  logic [pidtaw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pidtaw_pkg::DATA_W-1:0]         cfg_data
);

    // Config registers
    logic [pidtaw_pkg::GAIN_W-1:0]         gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [pidtaw_pkg::DATA_W-1:0]  upper_reg, lower_reg;

    // Sequencer
    pidtaw_pkg::state_t  state_reg, state_next;
    logic                half_reg, half_next;
    logic                in_accept;
    logic                out_load;
    logic                div_start;
    logic                mul_state;

    // Datapath
    logic signed [pidtaw_pkg::ERR_W-1:0]    err_reg, prev_reg;
    logic signed [pidtaw_pkg::DIFF_W-1:0]   diff_reg;
    logic signed [pidtaw_pkg::INTEG_W-1:0]  integral_reg, integral_next;
    logic signed [pidtaw_pkg::MUL_OP_W-1:0] p_reg;
    logic signed [pidtaw_pkg::ACC_W-1:0]    i_reg;
    logic signed [pidtaw_pkg::DATA_W-1:0]   drive_reg, drive_next;
    logic                                   out_valid_reg;

    logic signed [pidtaw_pkg::INTEG_W+1:0]  isum_wide;
    logic signed [pidtaw_pkg::INTEG_W-1:0]  isum_sat, lim, lim_neg;
    logic signed [pidtaw_pkg::INTEG_W:0]    lim_wide;
    logic [pidtaw_pkg::DATA_W-1:0]          upper_mag;
    logic signed [pidtaw_pkg::DATA_W:0]     upper_ext;
    logic signed [pidtaw_pkg::ACC_W-1:0]    total;

    // Shared unit hookups
    pidtaw_pkg::mul_ctl_t                   mul_ctl;
    logic [pidtaw_pkg::GAIN_W-1:0]          mul_gain;
    logic signed [pidtaw_pkg::MUL_OP_W-1:0] mul_operand;
    logic signed [pidtaw_pkg::ACC_W-1:0]    mul_acc;
    logic [pidtaw_pkg::INTEG_W-1:0]         div_dividend;
    logic [pidtaw_pkg::INTEG_W-1:0]         div_quotient;
    pidtaw_pkg::div_stat_t                  div_stat;

    assign in_accept = in_valid && !in_stall;

    // Config write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= pidtaw_pkg::GAIN_RESET;
            gain_i_reg <= pidtaw_pkg::GAIN_RESET;
            gain_d_reg <= pidtaw_pkg::GAIN_RESET;
            upper_reg  <= pidtaw_pkg::UPPER_RESET;
            lower_reg  <= pidtaw_pkg::LOWER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pidtaw_pkg::CFG_GAIN_P:      gain_p_reg <= cfg_data[pidtaw_pkg::GAIN_W-1:0];
                pidtaw_pkg::CFG_GAIN_I:      gain_i_reg <= cfg_data[pidtaw_pkg::GAIN_W-1:0];
                pidtaw_pkg::CFG_GAIN_D:      gain_d_reg <= cfg_data[pidtaw_pkg::GAIN_W-1:0];
                pidtaw_pkg::CFG_DRIVE_UPPER: upper_reg  <= cfg_data;
                pidtaw_pkg::CFG_DRIVE_LOWER: lower_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pidtaw_pkg::ST_IDLE:
            begin
                if (in_accept && mode == pidtaw_pkg::MODE_STEP)
                begin
                    state_next = (gain_i_reg != '0) ? pidtaw_pkg::ST_DIV
                                                    : pidtaw_pkg::ST_INTEG;
                end
            end
            pidtaw_pkg::ST_DIV:
            begin
                if (div_stat.last)
                begin
                    state_next = pidtaw_pkg::ST_INTEG;
                end
            end
            pidtaw_pkg::ST_INTEG: state_next = pidtaw_pkg::ST_MUL_P;
            pidtaw_pkg::ST_MUL_P:
            begin
                if (half_reg)
                begin
                    state_next = pidtaw_pkg::ST_MUL_I;
                end
            end
            pidtaw_pkg::ST_MUL_I:
            begin
                if (half_reg)
                begin
                    state_next = pidtaw_pkg::ST_MUL_D;
                end
            end
            pidtaw_pkg::ST_MUL_D:
            begin
                if (half_reg)
                begin
                    state_next = pidtaw_pkg::ST_DONE;
                end
            end
            pidtaw_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = pidtaw_pkg::ST_IDLE;
                end
            end
            default: state_next = pidtaw_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_stall    = (state_reg != pidtaw_pkg::ST_IDLE);
        div_start   = in_accept && (mode == pidtaw_pkg::MODE_STEP) && (gain_i_reg != '0);
        mul_state   = 1'b0;
        mul_gain    = '0;
        mul_operand = '0;
        unique case (state_reg)
            pidtaw_pkg::ST_MUL_P:
            begin
                mul_state   = 1'b1;
                mul_gain    = gain_p_reg;
                mul_operand = pidtaw_pkg::MUL_OP_W'(err_reg);
            end
            pidtaw_pkg::ST_MUL_I:
            begin
                mul_state   = 1'b1;
                mul_gain    = gain_i_reg;
                mul_operand = pidtaw_pkg::MUL_OP_W'(integral_reg);
            end
            pidtaw_pkg::ST_MUL_D:
            begin
                mul_state   = 1'b1;
                mul_gain    = gain_d_reg;
                mul_operand = pidtaw_pkg::MUL_OP_W'(diff_reg);
            end
            default: ;
        endcase
        mul_ctl.en    = mul_state;
        mul_ctl.first = !half_reg;
        half_next     = mul_state ? !half_reg : 1'b0;
        out_load      = (state_reg == pidtaw_pkg::ST_DONE) && (!out_valid_reg || !out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pidtaw_pkg::ST_IDLE;
            half_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            half_reg  <= half_next;
        end
    end

    // Divider dividend: |drive_upper| * 2^16
    always_comb
    begin
        upper_ext    = (pidtaw_pkg::DATA_W + 1)'(upper_reg);
        upper_mag    = upper_reg[pidtaw_pkg::DATA_W-1] ? pidtaw_pkg::DATA_W'(-upper_ext)
                                                       : pidtaw_pkg::DATA_W'(upper_ext);
        div_dividend = {upper_mag, {pidtaw_pkg::DIGIT_W{1'b0}}};
    end

    pidtaw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (gain_i_reg),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    pidtaw_mul u_mul (
        .clk     (clk),
        .ctl     (mul_ctl),
        .gain    (mul_gain),
        .operand (mul_operand),
        .acc     (mul_acc)
    );

    // Trapezoid update, saturate, then clamp to +/- limit; zero integral gain clears it
    always_comb
    begin
        isum_wide = (pidtaw_pkg::INTEG_W + 2)'(integral_reg)
                  + (pidtaw_pkg::INTEG_W + 2)'(err_reg)
                  + (pidtaw_pkg::INTEG_W + 2)'(prev_reg);
        if (isum_wide > (pidtaw_pkg::INTEG_W + 2)'(pidtaw_pkg::INT48_MAX))
        begin
            isum_sat = pidtaw_pkg::INT48_MAX;
        end
        else if (isum_wide < (pidtaw_pkg::INTEG_W + 2)'(pidtaw_pkg::INT48_MIN))
        begin
            isum_sat = pidtaw_pkg::INT48_MIN;
        end
        else
        begin
            isum_sat = isum_wide[pidtaw_pkg::INTEG_W-1:0];
        end

        lim_wide = upper_reg[pidtaw_pkg::DATA_W-1] ? -$signed({1'b0, div_quotient})
                                                   : $signed({1'b0, div_quotient});
        lim      = lim_wide[pidtaw_pkg::INTEG_W-1:0];
        lim_neg  = (lim == pidtaw_pkg::INT48_MIN) ? pidtaw_pkg::INT48_MAX : -lim;

        if (gain_i_reg == '0)
        begin
            integral_next = '0;
        end
        else if (isum_sat > lim)
        begin
            integral_next = lim;
        end
        else if (isum_sat < lim_neg)
        begin
            integral_next = lim_neg;
        end
        else
        begin
            integral_next = isum_sat;
        end
    end

    // Loop state: integral and last error
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            prev_reg     <= '0;
        end
        else if (in_accept && mode == pidtaw_pkg::MODE_CLEAR)
        begin
            integral_reg <= '0;
            prev_reg     <= '0;
        end
        else if (state_reg == pidtaw_pkg::ST_INTEG)
        begin
            integral_reg <= integral_next;
            prev_reg     <= err_reg;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            err_reg <= pidtaw_pkg::ERR_W'(target) - pidtaw_pkg::ERR_W'(measured);
        end
        if (state_reg == pidtaw_pkg::ST_INTEG)
        begin
            diff_reg <= pidtaw_pkg::DIFF_W'(err_reg) - pidtaw_pkg::DIFF_W'(prev_reg);
        end
        // P term lands as the I multiply starts, I term as the D multiply starts
        if (state_reg == pidtaw_pkg::ST_MUL_I && !half_reg)
        begin
            p_reg <= mul_acc[pidtaw_pkg::MUL_OP_W-1:0];
        end
        if (state_reg == pidtaw_pkg::ST_MUL_D && !half_reg)
        begin
            i_reg <= mul_acc;
        end
        if (out_load)
        begin
            drive_reg <= drive_next;
        end
    end

    // Sum of terms and output clamp (D term still in the multiplier)
    always_comb
    begin
        total = pidtaw_pkg::ACC_W'(p_reg) + i_reg + mul_acc;
        if (total > pidtaw_pkg::ACC_W'(upper_reg))
        begin
            drive_next = upper_reg;
        end
        else if (total < pidtaw_pkg::ACC_W'(lower_reg))
        begin
            drive_next = lower_reg;
        end
        else
        begin
            drive_next = total[pidtaw_pkg::DATA_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    // Zero integral gain skips the divide
    a_skip_div: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && mode == pidtaw_pkg::MODE_STEP && gain_i_reg == '0)
        |=> (state_reg == pidtaw_pkg::ST_INTEG))
        else $error("divide not skipped with zero integral gain");

    // Zero integral gain leaves a cleared integral for the I multiply
    a_integ_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pidtaw_pkg::ST_MUL_I && gain_i_reg == '0) |-> (integral_reg == '0))
        else $error("integral not cleared with zero integral gain");

    // A finished step presents its beat and frees the input side
    a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid && state_reg == pidtaw_pkg::ST_IDLE))
        else $error("result not presented after step end");

    // Divider runs only inside the divide phase
    a_div_phase: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == pidtaw_pkg::ST_DIV))
        else $error("divider busy outside divide phase");

endmodule

// ===== bench/pid_trapezoid_antiwindup_test.sv =====
`timescale 1ns / 100ps

module pid_trapezoid_antiwindup_test;

    // Indexes past the register list; writes there must be ignored
    localparam logic [pidtaw_pkg::CFG_IDX_W-1:0] CFG_SPARE_FIRST =
        pidtaw_pkg::CFG_DRIVE_LOWER + 3'd1;
    localparam logic [pidtaw_pkg::CFG_IDX_W-1:0] CFG_SPARE_LAST  = '1;

    localparam logic signed [pidtaw_pkg::DATA_W-1:0] Q_ONE  = 32'sh0001_0000;
    localparam logic signed [pidtaw_pkg::DATA_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [pidtaw_pkg::DATA_W-1:0] Q_MIN  = 32'sh8000_0000;
    localparam logic [pidtaw_pkg::GAIN_W-1:0]        K_MAX  = 31'h7FFF_FFFF;
    localparam int                                   SETTLE_CYCLES = 64;
    localparam int                                   PHASE_BEATS   = 112;
    localparam int                                   RANDOM_PHASES = 8;

    typedef struct packed {
        logic                                 md;
        logic signed [pidtaw_pkg::DATA_W-1:0] tgt;
        logic signed [pidtaw_pkg::DATA_W-1:0] meas;
    } pid_beat_t;

    // DUT ports
    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    logic                                 mode = pidtaw_pkg::MODE_STEP;
    logic signed [pidtaw_pkg::DATA_W-1:0] target = '0;
    logic signed [pidtaw_pkg::DATA_W-1:0] measured = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic signed [pidtaw_pkg::DATA_W-1:0] drive;
    logic                                 cfg_we = 1'b0;
    logic [pidtaw_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [pidtaw_pkg::DATA_W-1:0]        cfg_data = '0;

    // Shadow registers and controller state
    logic [pidtaw_pkg::GAIN_W-1:0]        k_p, k_i, k_d;
    logic signed [pidtaw_pkg::DATA_W-1:0] clamp_hi, clamp_lo;
    longint                               integ_acc;
    longint                               last_err;

    // Stimulus and expected drive values
    pid_beat_t                            beat_q[$];
    logic signed [pidtaw_pkg::DATA_W-1:0] drive_due[$];
    pid_beat_t                            nxt;
    longint                               sp_track;

    // Idling control
    bit                       snd_idle_on, rcv_idle_on;
    int unsigned              gap_left, stall_left;

    // Counters
    int unsigned              n_beats, n_clears, n_results, n_writes, n_settings;
    int unsigned              mismatches, stray_results;

    pid_trapezoid_antiwindup DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .target    (target),
        .measured  (measured),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive     (drive),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // floor(g * v / 2^16), exact
    function automatic longint mul_q16(input longint g, input longint v);
        logic signed [127:0] a, b, prod;
        a = g;
        b = v;
        prod = a * b;
        return longint'(prod >>> 16);
    endfunction

    // One controller step; returns 1 when a drive beat is due
    function automatic bit pid_step(input logic md,
                                    input logic signed [pidtaw_pkg::DATA_W-1:0] tgt,
                                    input logic signed [pidtaw_pkg::DATA_W-1:0] meas,
                                    output logic signed [pidtaw_pkg::DATA_W-1:0] drv);
        longint err, sum, lim, neg, up, lo, ki, p_term, i_term, d_term, total;
        drv = '0;
        if (md == pidtaw_pkg::MODE_CLEAR)
        begin
            integ_acc = 0;
            last_err  = 0;
            return 1'b0;
        end
        err = longint'(tgt) - longint'(meas);
        up  = clamp_hi;
        lo  = clamp_lo;
        ki  = k_i;
        p_term = mul_q16(k_p, err);

        // trapezoidal integral, saturate to 48 bits, then anti-windup clamp
        if (ki != 0)
        begin
            sum = integ_acc + err + last_err;
            if (sum > longint'(pidtaw_pkg::INT48_MAX))
                sum = pidtaw_pkg::INT48_MAX;
            else if (sum < longint'(pidtaw_pkg::INT48_MIN))
                sum = pidtaw_pkg::INT48_MIN;
            lim = (up * 65536) / ki;
            neg = -lim;
            if (neg > longint'(pidtaw_pkg::INT48_MAX))
                neg = pidtaw_pkg::INT48_MAX;
            if (sum > lim)
                sum = lim;
            else if (sum < neg)
                sum = neg;
            integ_acc = sum;
        end
        else
            integ_acc = 0;
        i_term = mul_q16(ki, integ_acc);

        d_term   = mul_q16(k_d, err - last_err);
        last_err = err;

        // upper bound is tested first, so it wins when the bounds cross
        total = p_term + i_term + d_term;
        if (total > up)
            total = up;
        else if (total < lo)
            total = lo;
        drv = total[pidtaw_pkg::DATA_W-1:0];
        return 1'b1;
    endfunction

    // Input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            mode     <= pidtaw_pkg::MODE_STEP;
            target   <= '0;
            measured <= '0;
            gap_left  = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                logic signed [pidtaw_pkg::DATA_W-1:0] drv;
                n_beats++;
                if (mode == pidtaw_pkg::MODE_CLEAR)
                    n_clears++;
                if (pid_step(mode, target, measured, drv))
                    drive_due.push_back(drv);
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (beat_q.size() != 0)
                begin
                    nxt = beat_q.pop_front();
                    mode     <= nxt.md;
                    target   <= nxt.tgt;
                    measured <= nxt.meas;
                    in_valid <= 1'b1;
                    if (snd_idle_on && $urandom_range(0, 7) == 0)
                        gap_left = $urandom_range(1, 15);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor and stall generator
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                logic signed [pidtaw_pkg::DATA_W-1:0] want;
                if (drive_due.size() == 0)
                begin
                    stray_results++;
                    if (mismatches + stray_results <= 10)
                        $display("unexpected drive beat %0d at %0t", drive, $realtime);
                end
                else
                begin
                    want = drive_due.pop_front();
                    n_results++;
                    if (drive !== want)
                    begin
                        mismatches++;
                        if (mismatches + stray_results <= 10)
                            $display("drive mismatch at %0t: expected %0d (%h), got %0d (%h)",
                                     $realtime, want, want, drive, drive);
                    end
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (rcv_idle_on && $urandom_range(0, 15) == 0)
            begin
                stall_left = $urandom_range(0, 14);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic cfg_write(input logic [pidtaw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pidtaw_pkg::DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            pidtaw_pkg::CFG_GAIN_P:      k_p = val[pidtaw_pkg::GAIN_W-1:0];
            pidtaw_pkg::CFG_GAIN_I:      k_i = val[pidtaw_pkg::GAIN_W-1:0];
            pidtaw_pkg::CFG_GAIN_D:      k_d = val[pidtaw_pkg::GAIN_W-1:0];
            pidtaw_pkg::CFG_DRIVE_UPPER: clamp_hi = val;
            pidtaw_pkg::CFG_DRIVE_LOWER: clamp_lo = val;
            default:                     ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        n_writes++;
    endtask

    task automatic load_gains(input logic [pidtaw_pkg::DATA_W-1:0] kp,
                              input logic [pidtaw_pkg::DATA_W-1:0] ki,
                              input logic [pidtaw_pkg::DATA_W-1:0] kd,
                              input logic [pidtaw_pkg::DATA_W-1:0] hi,
                              input logic [pidtaw_pkg::DATA_W-1:0] lo);
        cfg_write(pidtaw_pkg::CFG_GAIN_P, kp);
        cfg_write(pidtaw_pkg::CFG_GAIN_I, ki);
        cfg_write(pidtaw_pkg::CFG_GAIN_D, kd);
        cfg_write(pidtaw_pkg::CFG_DRIVE_UPPER, hi);
        cfg_write(pidtaw_pkg::CFG_DRIVE_LOWER, lo);
        n_settings++;
    endtask

    // Wait until every beat is sent and every drive beat has come, then let
    // a clear or a step still in the pipe finish
    task automatic settle();
        int unsigned guard = 0;
        @(posedge clk);
        while (!(beat_q.size() == 0 && !in_valid && gap_left == 0 && drive_due.size() == 0)
               && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void push_beat(input logic md,
                                      input logic signed [pidtaw_pkg::DATA_W-1:0] tgt,
                                      input logic signed [pidtaw_pkg::DATA_W-1:0] meas);
        pid_beat_t b;
        b.md   = md;
        b.tgt  = tgt;
        b.meas = meas;
        beat_q.push_back(b);
    endfunction

    function automatic logic signed [pidtaw_pkg::DATA_W-1:0] edge_value();
        case ($urandom_range(0, 4))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    function automatic logic [pidtaw_pkg::GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return K_MAX;
            2:       return pidtaw_pkg::GAIN_W'(1);
            3, 4:    return pidtaw_pkg::GAIN_W'($urandom_range(0, 32'h0004_0000));
            default: return pidtaw_pkg::GAIN_W'($urandom);
        endcase
    endfunction

    // Mostly a loop tracking a setpoint with noise; the rest clears,
    // full-range noise and edge values
    function automatic pid_beat_t make_beat();
        pid_beat_t   b;
        int unsigned pick;
        longint      span, noise;
        b.md   = pidtaw_pkg::MODE_STEP;
        b.tgt  = $urandom;
        b.meas = $urandom;
        pick   = $urandom_range(0, 15);
        if (pick == 0)
            b.md = pidtaw_pkg::MODE_CLEAR;
        else if (pick == 3)
        begin
            b.tgt  = edge_value();
            b.meas = edge_value();
        end
        else if (pick > 3)
        begin
            if ($urandom_range(0, 19) == 0)
                sp_track = int'($urandom) >>> $urandom_range(0, 12);
            span   = longint'(1) << $urandom_range(4, 24);
            noise  = longint'($urandom_range(0, 32'(2 * span))) - span;
            b.tgt  = sp_track;
            b.meas = 32'(sp_track + noise);
        end
        return b;
    endfunction

    task automatic random_settings();
        logic signed [pidtaw_pkg::DATA_W-1:0] hi, lo;
        case ($urandom_range(0, 5))
            0:
            begin
                hi = Q_MAX;
                lo = Q_MIN;
            end
            1, 2:
            begin
                hi = $urandom_range(1, 32'h0100_0000);
                lo = -int'($urandom_range(1, 32'h0100_0000));
            end
            3:
            begin
                hi = -int'($urandom_range(1, 32'h0010_0000));
                lo = Q_MIN;
            end
            4:
            begin
                lo = $urandom_range(32'h0001_0000, 32'h0100_0000);
                hi = lo - int'($urandom_range(1, 32'h0000_FFFF));
            end
            default:
            begin
                hi = $urandom;
                lo = $urandom;
            end
        endcase
        load_gains({1'($urandom), pick_gain()}, {1'($urandom), pick_gain()},
                   {1'($urandom), pick_gain()}, hi, lo);
        if ($urandom_range(0, 2) == 0)
            cfg_write(pidtaw_pkg::CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                      $urandom);
    endtask

    // Run limit
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        k_p = pidtaw_pkg::GAIN_RESET;
        k_i = pidtaw_pkg::GAIN_RESET;
        k_d = pidtaw_pkg::GAIN_RESET;
        clamp_hi = pidtaw_pkg::UPPER_RESET;
        clamp_lo = pidtaw_pkg::LOWER_RESET;
        integ_acc = 0;
        last_err  = 0;
        sp_track  = 0;
        snd_idle_on = 1'b1;
        rcv_idle_on = 1'b1;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // moderate gains, symmetric clamp at +/-100
        load_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0064_0000, 32'hFF9C_0000);
        push_beat(pidtaw_pkg::MODE_STEP, '0, '0);
        push_beat(pidtaw_pkg::MODE_STEP, Q_ONE, Q_ONE >>> 1);
        push_beat(pidtaw_pkg::MODE_STEP, Q_ONE, Q_ONE >>> 1);
        push_beat(pidtaw_pkg::MODE_STEP, 2 * Q_ONE, -3 * Q_ONE);
        push_beat(pidtaw_pkg::MODE_CLEAR, Q_MAX, Q_MIN);
        push_beat(pidtaw_pkg::MODE_STEP, Q_ONE >>> 2, '0);
        push_beat(pidtaw_pkg::MODE_STEP, Q_MAX, Q_MIN);
        push_beat(pidtaw_pkg::MODE_STEP, Q_MIN, Q_MAX);
        settle();

        // largest gains, bit 31 of the data set, full output range
        load_gains('1, '1, '1, Q_MAX, Q_MIN);
        push_beat(pidtaw_pkg::MODE_STEP, Q_MAX, Q_MIN);
        push_beat(pidtaw_pkg::MODE_STEP, Q_MIN, Q_MAX);
        push_beat(pidtaw_pkg::MODE_STEP, Q_MAX, Q_MAX);
        push_beat(pidtaw_pkg::MODE_STEP, -1, '0);
        push_beat(pidtaw_pkg::MODE_CLEAR, '0, '0);
        push_beat(pidtaw_pkg::MODE_STEP, 1, '0);
        settle();

        // integral gain of one LSB, negative upper bound below the lower bound
        load_gains('0, 32'h0000_0001, '0, Q_MIN, Q_MAX);
        push_beat(pidtaw_pkg::MODE_STEP, Q_MAX, Q_MIN);
        push_beat(pidtaw_pkg::MODE_STEP, Q_MIN, Q_MAX);
        push_beat(pidtaw_pkg::MODE_STEP, '0, '0);
        settle();

        // integral off; writes past the register list change nothing
        load_gains(32'h0001_0000, '0, 32'h0002_0000, Q_MAX, Q_MIN);
        for (int idx = CFG_SPARE_FIRST; idx <= CFG_SPARE_LAST; idx++)
            cfg_write(pidtaw_pkg::CFG_IDX_W'(idx), $urandom);
        push_beat(pidtaw_pkg::MODE_STEP, 3 * Q_ONE, Q_ONE);
        push_beat(pidtaw_pkg::MODE_STEP, -3 * Q_ONE, Q_ONE);
        push_beat(pidtaw_pkg::MODE_CLEAR, Q_MIN, Q_MAX);
        push_beat(pidtaw_pkg::MODE_STEP, Q_MIN, Q_MAX);
        settle();

        // random settings, each followed by a burst of beats
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            random_settings();
            snd_idle_on = (ph % 3 != 2) && (ph != RANDOM_PHASES - 1);
            rcv_idle_on = (ph % 4 != 1) && (ph != RANDOM_PHASES - 1);
            sp_track = int'($urandom) >>> $urandom_range(0, 12);
            for (int n = 0; n < PHASE_BEATS; n++)
                beat_q.push_back(make_beat());
            settle();
        end

        if (drive_due.size() != 0)
            $display("%0d drive beats never arrived", drive_due.size());
        $display("Sent %0d beats (%0d clears) under %0d register settings, %0d writes.",
                 n_beats, n_clears, n_settings, n_writes);
        $display("Checked %0d drive beats: %0d mismatched, %0d unexpected.",
                 n_results, mismatches, stray_results);
        if (mismatches == 0 && stray_results == 0 && drive_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/pidtaw_pkg.sv
src/pidtaw_div.sv
src/pidtaw_mul.sv
src/pid_trapezoid_antiwindup.sv
bench/pid_trapezoid_antiwindup_test.sv
